// ===== design/assert_macros.svh =====
// Assertion macros for the RTL files that check their own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge, off while reset is asserted.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequence is checked at the next rising clock edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/hslrgb_pkg.sv =====
// Package with types and constants of the HSL/HSV to RGB converter.
`default_nettype none

package hslrgb_pkg;

    localparam int FRAC_BITS   = 12;
    localparam int CH_W        = FRAC_BITS + 1;   // 0..1.0 inclusive
    localparam int HUE_W       = 16;
    localparam int SL_W        = 14;              // signed saturation / level input
    localparam int NUM_STAGES  = 6;

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 56;

    localparam logic [CH_W-1:0] ONE_Q = CH_W'(1 << FRAC_BITS);
    localparam logic [CH_W-1:0] HALF_Q = CH_W'(1 << (FRAC_BITS - 1));

    // Hue is offset by six full circles so the wrapped value stays unsigned.
    localparam logic [16:0] HUE_BIAS = 17'd1792;  // added to hue + 32768
    localparam logic [9:0]  SECTOR_W = 10'd960;   // 60 degrees in 1/16 degree

    // Reciprocals for division by constants (checked over the value ranges used).
    localparam logic [12:0] RECIP15_HUE = 13'd4370;   // (w * 4370) >> 16 = w / 15
    localparam logic [5:0]  RECIP6      = 6'd43;      // (q * 43) >> 8 = q / 6
    localparam logic [16:0] RECIP15_X   = 17'd69906;  // (p * 69906) >> 20 = p / 15

    typedef enum logic {
        MODE_HSL = 1'b0,
        MODE_HSV = 1'b1
    } color_mode_t;

    typedef enum logic [2:0] {
        SEC_RED_YEL  = 3'd0,
        SEC_YEL_GRN  = 3'd1,
        SEC_GRN_CYN  = 3'd2,
        SEC_CYN_BLU  = 3'd3,
        SEC_BLU_MAG  = 3'd4,
        SEC_MAG_RED  = 3'd5
    } sector_t;

    function automatic logic [CH_W-1:0] clamp_unit(input logic signed [SL_W-1:0] v);
        logic [CH_W-1:0] r;
        if (v[SL_W-1])
            r = '0;
        else if (v > $signed({1'b0, ONE_Q}))
            r = ONE_Q;
        else
            r = v[CH_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/hslrgb_datapath.sv =====
// Six-stage arithmetic datapath of the HSL/HSV to RGB converter.
`default_nettype none

module hslrgb_datapath
    import hslrgb_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic [NUM_STAGES-1:0] adv,        // load enable per stage
    input  wire color_mode_t           color_mode,
    input  wire logic [HUE_W-1:0]      hue,
    input  wire logic [SL_W-1:0]       saturation,
    input  wire logic [SL_W-1:0]       level,
    input  wire logic [CH_W-1:0]       alpha,
    output logic [CH_W-1:0]            red,
    output logic [CH_W-1:0]            green,
    output logic [CH_W-1:0]            blue,
    output logic [CH_W-1:0]            alpha_out
);

    // stage 1: clamp, bias hue
    logic [CH_W-1:0]  s1_sat_reg, s1_lvl_reg, s1_alpha_reg;
    logic [16:0]      s1_hue_reg;
    color_mode_t      s1_mode_reg;
    logic [16:0]      s1_hue_next;

    // stage 2: chroma product, coarse hue quotient
    logic [CH_W-1:0]  s2_c_reg, s2_lvl_reg, s2_alpha_reg;
    logic [16:0]      s2_hue_reg;
    logic [6:0]       s2_q_reg;
    color_mode_t      s2_mode_reg;
    logic [13:0]      s2_two_l;
    logic [CH_W-1:0]  s2_one_m_d;
    logic [CH_W-1:0]  s2_mul_a;
    logic [25:0]      s2_cprod;
    logic [23:0]      s2_qprod;

    // stage 3: position in sector, sector index, offset m
    logic [CH_W-1:0]  s3_c_reg, s3_m_reg, s3_alpha_reg;
    logic [9:0]       s3_f_reg;
    logic [2:0]       s3_sec_reg;
    logic [16:0]      s3_f_full;
    logic [11:0]      s3_q43;
    logic [3:0]       s3_q6;
    logic [6:0]       s3_sec_full;
    logic [CH_W-1:0]  s3_m_next;

    // stage 4: c * t / 64
    logic [CH_W-1:0]  s4_c_reg, s4_m_reg, s4_alpha_reg;
    logic [15:0]      s4_p_reg;
    logic [2:0]       s4_sec_reg;
    logic [9:0]       s4_t;
    logic [22:0]      s4_prod;

    // stage 5: secondary term x
    logic [CH_W-1:0]  s5_c_reg, s5_m_reg, s5_alpha_reg, s5_x_reg;
    logic [2:0]       s5_sec_reg;
    logic [32:0]      s5_xprod;

    // stage 6: output register
    logic [CH_W-1:0]  r_reg, g_reg, b_reg, a_reg;
    logic [CH_W-1:0]  r_next, g_next, b_next;
    logic [CH_W-1:0]  r1, g1, b1;

    assign s1_hue_next = {1'b0, ~hue[HUE_W-1], hue[HUE_W-2:0]} + HUE_BIAS;

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s1_sat_reg   <= clamp_unit(saturation);
            s1_lvl_reg   <= clamp_unit(level);
            s1_hue_reg   <= s1_hue_next;
            s1_alpha_reg <= alpha;
            s1_mode_reg  <= color_mode;
        end
    end

    always_comb
    begin
        s2_two_l = {s1_lvl_reg, 1'b0};
        // 1 - |2l - 1|
        if (s1_lvl_reg < HALF_Q)
            s2_one_m_d = s2_two_l[CH_W-1:0];
        else
            s2_one_m_d = CH_W'(14'd8192 - s2_two_l);
        s2_mul_a = (s1_mode_reg == MODE_HSV) ? s1_lvl_reg : s2_one_m_d;
        s2_cprod = s2_mul_a * s1_sat_reg;
        s2_qprod = s1_hue_reg[16:6] * RECIP15_HUE;
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s2_c_reg     <= s2_cprod[24:12];
            s2_q_reg     <= s2_qprod[22:16];
            s2_hue_reg   <= s1_hue_reg;
            s2_lvl_reg   <= s1_lvl_reg;
            s2_alpha_reg <= s1_alpha_reg;
            s2_mode_reg  <= s1_mode_reg;
        end
    end

    always_comb
    begin
        s3_f_full   = s2_hue_reg - ({s2_q_reg, 10'd0} - {4'd0, s2_q_reg, 6'd0});
        s3_q43      = s2_q_reg * RECIP6;
        s3_q6       = s3_q43[11:8];
        s3_sec_full = s2_q_reg - 7'({s3_q6, 2'b00} + {s3_q6, 1'b0});
        if (s2_mode_reg == MODE_HSV)
            s3_m_next = s2_lvl_reg - s2_c_reg;
        else
            s3_m_next = s2_lvl_reg - {1'b0, s2_c_reg[CH_W-1:1]};
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            s3_f_reg     <= s3_f_full[9:0];
            s3_sec_reg   <= s3_sec_full[2:0];
            s3_c_reg     <= s2_c_reg;
            s3_m_reg     <= s3_m_next;
            s3_alpha_reg <= s2_alpha_reg;
        end
    end

    always_comb
    begin
        // falling edge of x in odd sectors
        s4_t    = s3_sec_reg[0] ? (SECTOR_W - s3_f_reg) : s3_f_reg;
        s4_prod = s3_c_reg * s4_t;
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            s4_p_reg     <= s4_prod[21:6];
            s4_sec_reg   <= s3_sec_reg;
            s4_c_reg     <= s3_c_reg;
            s4_m_reg     <= s3_m_reg;
            s4_alpha_reg <= s3_alpha_reg;
        end
    end

    assign s5_xprod = s4_p_reg * RECIP15_X;

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            s5_x_reg     <= s5_xprod[32:20];
            s5_sec_reg   <= s4_sec_reg;
            s5_c_reg     <= s4_c_reg;
            s5_m_reg     <= s4_m_reg;
            s5_alpha_reg <= s4_alpha_reg;
        end
    end

    always_comb
    begin
        r1 = '0;
        g1 = '0;
        b1 = '0;
        case (sector_t'(s5_sec_reg))
            SEC_RED_YEL:
            begin
                r1 = s5_c_reg;
                g1 = s5_x_reg;
            end
            SEC_YEL_GRN:
            begin
                r1 = s5_x_reg;
                g1 = s5_c_reg;
            end
            SEC_GRN_CYN:
            begin
                g1 = s5_c_reg;
                b1 = s5_x_reg;
            end
            SEC_CYN_BLU:
            begin
                g1 = s5_x_reg;
                b1 = s5_c_reg;
            end
            SEC_BLU_MAG:
            begin
                r1 = s5_x_reg;
                b1 = s5_c_reg;
            end
            default:
            begin
                r1 = s5_c_reg;
                b1 = s5_x_reg;
            end
        endcase
        r_next = r1 + s5_m_reg;
        g_next = g1 + s5_m_reg;
        b_next = b1 + s5_m_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            r_reg <= r_next;
            g_reg <= g_next;
            b_reg <= b_next;
            a_reg <= s5_alpha_reg;
        end
    end

    assign red       = r_reg;
    assign green     = g_reg;
    assign blue      = b_reg;
    assign alpha_out = a_reg;

endmodule

`default_nettype wire

// ===== design/hsl_hsv_to_rgb_top.sv =====
// Top level of the HSL/HSV to RGB converter: stream handshake, mode register, datapath.
`default_nettype none

// Converts HSL or HSV pixels into Q12 red, green and blue, alpha copied
// through. An accepted pixel is loaded into stage 1 and moves through the
// stage registers in order to the output register, stage 6; each of the six
// pipeline stages moves on its own, so a stall at the output only backs up
// as far as the first empty stage and one pixel per cycle is sustained while
// the output side keeps tready high. Hue wraps modulo 360 degrees, saturation
// and level clamp to 0..1.0. cfg_data bit 0 selects HSL (0) or HSV (1); write
// it only while no pixel is in flight. The mode register resets to HSL.

`include "assert_macros.svh"

module hsl_hsv_to_rgb_top
    import hslrgb_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic                   cfg_data,       // color_mode
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // hue[15:0], saturation[29:16], level[43:30], alpha[56:44], zero[63:57]
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // red[12:0], green[25:13], blue[38:26], alpha_out[51:39], zero[55:52]
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

    color_mode_t           mode_reg;
    logic [NUM_STAGES-1:0] valid_reg, valid_next;
    logic [NUM_STAGES-1:0] adv;
    logic [CH_W-1:0]       red, green, blue, alpha_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_HSL;
        else if (cfg_valid && cfg_ready)
            mode_reg <= color_mode_t'(cfg_data);
    end

    // A stage loads when it is empty or its content moves on.
    always_comb
    begin
        adv[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_axis_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
            adv[k] = !valid_reg[k] || adv[k+1];
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (adv[0])
            valid_next[0] = s_axis_tvalid;
        for (int k = 1; k < NUM_STAGES; k++)
            if (adv[k])
                valid_next[k] = valid_reg[k-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    hslrgb_datapath u_datapath (
        .clk        (clk),
        .adv        (adv),
        .color_mode (mode_reg),
        .hue        (s_axis_tdata[15:0]),
        .saturation (s_axis_tdata[29:16]),
        .level      (s_axis_tdata[43:30]),
        .alpha      (s_axis_tdata[56:44]),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .alpha_out  (alpha_out)
    );

    assign s_axis_tready = adv[0];
    assign m_axis_tvalid = valid_reg[NUM_STAGES-1];
    assign m_axis_tdata  = {4'd0, alpha_out, blue, green, red};

    `ASSERT_IMPL(a_ready_through, m_axis_tready, s_axis_tready, "input stalled while output is taken")
    `ASSERT_IMPL(a_empty_out_ready, !m_axis_tvalid, s_axis_tready, "input stalled with empty output stage")
    `ASSERT_IMPL(a_chan_range, m_axis_tvalid, (red <= ONE_Q) && (green <= ONE_Q) && (blue <= ONE_Q), "channel above full scale")
    `ASSERT_NEXT(a_enter, s_axis_tvalid && s_axis_tready, valid_reg[0], "accepted transfer not captured")

endmodule

`default_nettype wire
